// ----- hdl/msps_pkg.sv -----
package msps_pkg;

    // Fixed field widths of the block's ports.
    localparam int ELEM_W    = 32;
    localparam int DIM_W     = 5;
    localparam int POS_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Default matrix bounds handed to the top level.
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CAND_RD,
        ST_CAND_CAP,
        ST_ROW_RD,
        ST_ROW_CMP,
        ST_COL_RD,
        ST_COL_CMP
    } t_state;

    // Which pair of indexes forms the store read address.
    typedef enum logic [1:0] {
        ASEL_CAND,
        ASEL_ROW,
        ASEL_COL
    } t_addr_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_write;
        logic      start;
        logic      next_cand;
        logic      cap_cand;
        logic      k_clr;
        logic      k_inc;
        logic      out_write;
        logic      out_found;
        logic      searching;
        t_addr_sel addr_sel;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic load_last;
        logic cand_last;
        logic k_is_row;
        logic k_is_col;
        logic k_last_row;
        logic k_last_col;
        logic row_ok;
        logic col_ok;
    } t_ctrl_status;

endpackage

// ----- hdl/msps_ram.sv -----
module msps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/msps_ctrl.sv -----
module msps_ctrl import msps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   accept;

    // The last element of a matrix may only enter once the result register is free.
    assign in_ready   = (r_state == ST_LOAD) && !(i_status.out_valid && i_status.load_last);
    assign accept     = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_status.load_last) begin
                    n_state = ST_CAND_RD;
                end
            end
            ST_CAND_RD:  n_state = ST_CAND_CAP;
            ST_CAND_CAP: n_state = ST_ROW_RD;
            ST_ROW_RD: begin
                if (!i_status.k_is_col) begin
                    n_state = ST_ROW_CMP;
                end else if (i_status.k_last_row) begin
                    n_state = ST_COL_RD;
                end
            end
            ST_ROW_CMP: begin
                if (!i_status.row_ok) begin
                    n_state = i_status.cand_last ? ST_LOAD : ST_CAND_RD;
                end else if (i_status.k_last_row) begin
                    n_state = ST_COL_RD;
                end else begin
                    n_state = ST_ROW_RD;
                end
            end
            ST_COL_RD: begin
                if (!i_status.k_is_row) begin
                    n_state = ST_COL_CMP;
                end else if (i_status.k_last_col) begin
                    n_state = ST_LOAD;
                end
            end
            ST_COL_CMP: begin
                if (!i_status.col_ok) begin
                    n_state = i_status.cand_last ? ST_LOAD : ST_CAND_RD;
                end else if (i_status.k_last_col) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_COL_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.addr_sel  = ASEL_CAND;
        o_cmd.searching = (r_state != ST_LOAD);
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.load_write = accept;
                o_cmd.start      = accept && i_status.load_last;
            end
            ST_CAND_RD: begin
                o_cmd.addr_sel = ASEL_CAND;
            end
            ST_CAND_CAP: begin
                o_cmd.cap_cand = 1'b1;
                o_cmd.k_clr    = 1'b1;
            end
            ST_ROW_RD: begin
                o_cmd.addr_sel = ASEL_ROW;
                // The candidate's own column is skipped without a read.
                if (i_status.k_is_col) begin
                    o_cmd.k_clr = i_status.k_last_row;
                    o_cmd.k_inc = !i_status.k_last_row;
                end
            end
            ST_ROW_CMP: begin
                o_cmd.addr_sel = ASEL_ROW;
                if (!i_status.row_ok) begin
                    o_cmd.next_cand = !i_status.cand_last;
                    o_cmd.out_write = i_status.cand_last;
                end else begin
                    o_cmd.k_clr = i_status.k_last_row;
                    o_cmd.k_inc = !i_status.k_last_row;
                end
            end
            ST_COL_RD: begin
                o_cmd.addr_sel = ASEL_COL;
                // The candidate's own row is skipped without a read.
                if (i_status.k_is_row) begin
                    o_cmd.out_write = i_status.k_last_col;
                    o_cmd.out_found = i_status.k_last_col;
                    o_cmd.k_inc     = !i_status.k_last_col;
                end
            end
            ST_COL_CMP: begin
                o_cmd.addr_sel = ASEL_COL;
                if (!i_status.col_ok) begin
                    o_cmd.next_cand = !i_status.cand_last;
                    o_cmd.out_write = i_status.cand_last;
                end else begin
                    o_cmd.out_write = i_status.k_last_col;
                    o_cmd.out_found = i_status.k_last_col;
                    o_cmd.k_inc     = !i_status.k_last_col;
                end
            end
            default: begin
                o_cmd.addr_sel = ASEL_CAND;
            end
        endcase
    end

endmodule

// ----- hdl/msps_datapath.sv -----
module msps_datapath import msps_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic [ELEM_W-1:0]    i_element_value,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_status         o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_saddle_row,
    output logic [POS_W-1:0]     o_saddle_col
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int RDW   = $clog2(MAX_ROWS + 1);
    localparam int CDW   = $clog2(MAX_COLS + 1);
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW    = (RIW > CIW) ? RIW : CIW;
    localparam int LW    = KW + CDW + 1;

    logic [DIM_W-1:0]         r_num_rows;
    logic [DIM_W-1:0]         r_num_cols;
    logic [RDW-1:0]           rows_eff;
    logic [CDW-1:0]           cols_eff;
    logic [TW-1:0]            total;
    logic [AW-1:0]            r_load_count;
    logic [TW-1:0]            count_next;
    logic                     load_last;
    logic [RIW-1:0]           r_row;
    logic [CIW-1:0]           r_col;
    logic [KW-1:0]            r_k;
    logic signed [ELEM_W-1:0] r_cand;
    logic signed [ELEM_W-1:0] rd_val;
    logic [ELEM_W-1:0]        ram_rdata;
    logic [KW-1:0]            addr_r;
    logic [KW-1:0]            addr_c;
    logic [LW-1:0]            lin_addr;
    logic [AW-1:0]            rd_addr;
    logic                     row_last;
    logic                     col_last;
    logic                     r_out_valid;
    logic                     r_found;
    logic [POS_W-1:0]         r_saddle_row;
    logic [POS_W-1:0]         r_saddle_col;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(1);
            r_num_cols <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                REG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes in use: zero counts as one, anything past the maximum as the maximum.
    always_comb begin
        if (r_num_rows == '0) begin
            rows_eff = RDW'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_eff = RDW'(MAX_ROWS);
        end else begin
            rows_eff = RDW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            cols_eff = CDW'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = CDW'(MAX_COLS);
        end else begin
            cols_eff = CDW'(r_num_cols);
        end
    end

    assign total      = TW'((RDW + CDW)'(rows_eff) * (RDW + CDW)'(cols_eff));
    assign count_next = TW'(r_load_count) + TW'(1);
    assign load_last  = (count_next >= total);

    // Load counter: the write address of the next element.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (i_cmd.load_write) begin
            r_load_count <= load_last ? '0 : (r_load_count + AW'(1));
        end
    end

    // Search indexes: candidate position and the scan index along its row or column.
    assign row_last = (32'(r_row) + 32'd1 == 32'(rows_eff));
    assign col_last = (32'(r_col) + 32'd1 == 32'(cols_eff));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.next_cand) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + RIW'(1);
            end else begin
                r_col <= r_col + CIW'(1);
            end
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.cap_cand) begin
            r_cand <= rd_val;
        end
    end

    // Read address: row index times the column count plus column index.
    always_comb begin
        unique case (i_cmd.addr_sel)
            ASEL_CAND: begin
                addr_r = KW'(r_row);
                addr_c = KW'(r_col);
            end
            ASEL_ROW: begin
                addr_r = KW'(r_row);
                addr_c = r_k;
            end
            ASEL_COL: begin
                addr_r = r_k;
                addr_c = KW'(r_col);
            end
            default: begin
                addr_r = '0;
                addr_c = '0;
            end
        endcase
    end

    assign lin_addr = LW'(addr_r) * LW'(cols_eff) + LW'(addr_c);
    assign rd_addr  = lin_addr[AW-1:0];

    msps_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_write),
        .i_waddr (r_load_count),
        .i_wdata (i_element_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = $signed(ram_rdata);

    // Result register, held until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_found      <= i_cmd.out_found;
            r_saddle_row <= i_cmd.out_found ? POS_W'(r_row) : '0;
            r_saddle_col <= i_cmd.out_found ? POS_W'(r_col) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_saddle_row = r_saddle_row;
    assign o_saddle_col = r_saddle_col;

    // Status back to the controller.
    always_comb begin
        o_status            = '0;
        o_status.out_valid  = r_out_valid;
        o_status.load_last  = load_last;
        o_status.cand_last  = row_last && col_last;
        o_status.k_is_row   = (32'(r_k) == 32'(r_row));
        o_status.k_is_col   = (32'(r_k) == 32'(r_col));
        o_status.k_last_row = (32'(r_k) + 32'd1 == 32'(cols_eff));
        o_status.k_last_col = (32'(r_k) + 32'd1 == 32'(rows_eff));
        o_status.row_ok     = (rd_val < r_cand);
        o_status.col_ok     = (r_cand < rd_val);
    end

endmodule

// ----- hdl/matrix_saddle_point_search_core.sv -----
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_ready       i_element_value
// result    out        o_out_valid / i_out_ready     o_found, o_saddle_row, o_saddle_col
// config    in         i_cfg_we (write only)         i_cfg_index, i_cfg_data
//
// Each element is written to the store at its row-major place as it is taken.
// After the last element the search holds the input off. Each candidate is read
// and captured, then each other element of its row and then of its column is read
// and compared, its own place skipped without a read; a candidate stops at its
// first failed compare. All reads go through the store's single registered read
// port. Reset clears control state only; no store entry is read before it is
// written. A waiting result holds only the last element of the next matrix.
module matrix_saddle_point_search_core import msps_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ELEM_W-1:0]    i_element_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_saddle_row,
    output logic [POS_W-1:0]     o_saddle_col
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    msps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    msps_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_element_value (i_element_value),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_saddle_row    (o_saddle_row),
        .o_saddle_col    (o_saddle_col)
    );

    // No element request is taken while a search runs.
    a_no_accept_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.searching |-> !o_in_ready)
        else $error("input request accepted during a search");

    // A search only finishes into an empty result register.
    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_write |-> !status.out_valid)
        else $error("result written over a waiting result");

    // A search starts only after the request that completed a matrix.
    a_search_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(cmd.searching) |-> $past(i_in_valid && o_in_ready && status.load_last))
        else $error("search started without a completed matrix");

endmodule
